FILE: hdl/xkwd_pkg.sv
`timescale 1ns / 1ps

package xkwd_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned KEY_WORDS = 4;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [WORD_W-1:0] MIX_DELTA = 32'h9e37_79b9;

	localparam logic CMD_BEGIN = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef enum logic [1:0] {
		STAT_BEGIN = 2'd0,
		STAT_DATA = 2'd1,
		STAT_EARLY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_PRIME,
		ST_MIX
	} state_t;

endpackage

FILE: hdl/xkwd_if.sv
`timescale 1ns / 1ps

interface xkwd_in_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [xkwd_pkg::WORD_W-1:0] data_word;
	logic last_word;

	modport source (output valid, output cmd, output data_word, output last_word, input ready);
	modport sink (input valid, input cmd, input data_word, input last_word, output ready);
endinterface

interface xkwd_out_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [xkwd_pkg::WORD_W-1:0] plain_word;
	logic [xkwd_pkg::WORD_W-1:0] running_xor;
	logic last_out;

	modport source (output valid, output status, output plain_word, output running_xor,
		output last_out, input ready);
	modport sink (input valid, input status, input plain_word, input running_xor,
		input last_out, output ready);
endinterface

FILE: hdl/xxtea_keystream_word_decrypt.sv
`timescale 1ns / 1ps
// data word: result passes the data stage and the output register; one word per cycle
// sustained while rsp.ready holds; begin: result enters the data stage when the build ends
// with input held off, one keystream word mixed per cycle through the single write /
// single read port pair of the keystream ram
// reset clears counters, key and the ready flag; the ram is not cleared, since every
// begin rewrites all entries before any data word reads them

module xxtea_keystream_word_decrypt #(
	parameter int STREAM_WORDS = 1024,
	parameter int ROUND_COUNT = 6,
	parameter int FULL_WORDS = 512,
	parameter int SKIP_STRIDE = 64,
	parameter int CHECK_WORDS = 128
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [xkwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [xkwd_pkg::WORD_W-1:0]       cfg_data,
	xkwd_in_if.sink                           req,
	xkwd_out_if.source                        rsp
);

	localparam int AW = $clog2(STREAM_WORDS);
	localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int WSW = $clog2(FULL_WORDS + 2);
	localparam int SW = (SKIP_STRIDE > 1) ? $clog2(SKIP_STRIDE) : 1;
	localparam int CW = $clog2(CHECK_WORDS + 1);
	localparam int W = xkwd_pkg::WORD_W;
	localparam logic [AW-1:0] P_LAST = AW'(STREAM_WORDS - 1);
	localparam logic [RW-1:0] R_LAST = RW'(ROUND_COUNT - 1);
	localparam logic [SW-1:0] PH_LAST = SW'(SKIP_STRIDE - 1);

	xkwd_pkg::state_t state_q, state_d;

	logic [W-1:0] key_q [xkwd_pkg::KEY_WORDS];
	logic [AW-1:0] p_q;
	logic [RW-1:0] round_q;
	logic [W-1:0] sum_q, z_q, cur_q, first_q;
	logic ready_q;
	logic [WSW-1:0] words_seen_q;
	logic [SW-1:0] phase_q;
	logic [AW-1:0] key_index_q;
	logic [CW-1:0] check_cnt_q;
	logic [W-1:0] check_acc_q;

	logic v_s1, xor_s1, last_s1;
	xkwd_pkg::status_t status_s1;
	logic [W-1:0] word_s1;
	logic byp_s1;
	logic [W-1:0] wdata_s1;

	logic out_v_q, out_last_q;
	xkwd_pkg::status_t out_status_q;
	logic [W-1:0] out_word_q, out_xor_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [W-1:0] ram_wdata, ram_rdata, ks;

	logic out_free, mv, acc, acc_data, acc_begin, do_xor;
	logic p_last, build_done;
	logic [AW:0] p_plus2;
	logic [1:0] kidx;
	logic [W-1:0] y_sel, mix_a, mix_b;
	logic [W-1:0] plain_s1, acc_next;

	xkwd_ram #(.WIDTH(W), .DEPTH(STREAM_WORDS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(p_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// handshake
	assign out_free = !out_v_q || rsp.ready;
	assign mv = v_s1 && out_free;
	assign req.ready = (state_q == xkwd_pkg::ST_RUN) && (!v_s1 || out_free);
	assign acc = req.valid && req.ready;
	assign acc_data = acc && (req.cmd == xkwd_pkg::CMD_DATA);
	assign acc_begin = acc && (req.cmd == xkwd_pkg::CMD_BEGIN);
	assign do_xor = (words_seen_q < WSW'(FULL_WORDS)) || (phase_q == '0);

	// read data with forwarding of a same-cycle write
	assign ks = byp_s1 ? wdata_s1 : ram_rdata;

	// block mix
	assign p_last = (p_q == P_LAST);
	assign build_done = (state_q == xkwd_pkg::ST_MIX) && p_last && (round_q == R_LAST);
	assign p_plus2 = {1'b0, p_q} + (AW + 1)'(2);
	assign kidx = 2'(p_q) ^ sum_q[3:2];
	assign y_sel = p_last ? first_q : ((round_q == '0) ? '0 : ks);
	assign mix_a = ((z_q >> 5) ^ (y_sel << 2)) + ((y_sel >> 3) ^ (z_q << 4));
	assign mix_b = (sum_q ^ y_sel) + (key_q[kidx] ^ z_q);
	assign ram_wdata = cur_q + (mix_a ^ mix_b);

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_re = 1'b0;
		ram_raddr = key_index_q;
		case (state_q)
			xkwd_pkg::ST_RUN: begin
				if (acc_begin) begin
					state_d = xkwd_pkg::ST_PRIME;
				end
				if (acc_data && ready_q && do_xor) begin
					ram_re = 1'b1;
				end
			end
			xkwd_pkg::ST_PRIME: begin
				ram_re = 1'b1;
				ram_raddr = AW'(1);
				state_d = xkwd_pkg::ST_MIX;
			end
			xkwd_pkg::ST_MIX: begin
				ram_we = 1'b1;
				if (p_last) begin
					if (round_q == R_LAST) begin
						state_d = xkwd_pkg::ST_RUN;
					end else begin
						ram_re = 1'b1;
						ram_raddr = AW'(1);
					end
				end else begin
					ram_re = (p_plus2 < (AW + 1)'(STREAM_WORDS));
					ram_raddr = p_plus2[AW-1:0];
				end
			end
			default: begin
				state_d = xkwd_pkg::ST_RUN;
			end
		endcase
	end

	// output of the data stage
	always_comb begin
		plain_s1 = '0;
		acc_next = check_acc_q;
		case (status_s1)
			xkwd_pkg::STAT_DATA: begin
				plain_s1 = word_s1 ^ (xor_s1 ? ks : '0);
				if (check_cnt_q < CW'(CHECK_WORDS)) begin
					acc_next = check_acc_q ^ plain_s1;
				end
			end
			xkwd_pkg::STAT_EARLY: begin
				plain_s1 = word_s1;
			end
			default: begin
				plain_s1 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xkwd_pkg::ST_RUN;
			for (int i = 0; i < xkwd_pkg::KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
			p_q <= '0;
			round_q <= '0;
			ready_q <= 1'b0;
			words_seen_q <= '0;
			phase_q <= '0;
			key_index_q <= '0;
			check_cnt_q <= '0;
			check_acc_q <= '0;
			v_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				key_q[cfg_index] <= cfg_data;
			end
			byp_s1 <= ram_re && ram_we && (ram_raddr == p_q);

			if (acc_begin) begin
				p_q <= '0;
				round_q <= '0;
			end else if (state_q == xkwd_pkg::ST_MIX) begin
				if (p_last) begin
					p_q <= '0;
					round_q <= round_q + RW'(1);
				end else begin
					p_q <= p_q + AW'(1);
				end
			end

			if (build_done) begin
				ready_q <= 1'b1;
				words_seen_q <= '0;
				phase_q <= '0;
				key_index_q <= '0;
				check_cnt_q <= '0;
				check_acc_q <= '0;
			end else begin
				if (acc_data && ready_q) begin
					if (words_seen_q < WSW'(FULL_WORDS)) begin
						words_seen_q <= words_seen_q + WSW'(1);
					end else begin
						phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + SW'(1);
					end
					if (do_xor) begin
						key_index_q <= (key_index_q == P_LAST) ? '0 : key_index_q + AW'(1);
					end
				end
				if (mv && status_s1 == xkwd_pkg::STAT_DATA
						&& check_cnt_q < CW'(CHECK_WORDS)) begin
					check_cnt_q <= check_cnt_q + CW'(1);
					check_acc_q <= acc_next;
				end
			end

			if (acc_data || build_done) begin
				v_s1 <= 1'b1;
			end else if (mv) begin
				v_s1 <= 1'b0;
			end

			if (mv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wdata_s1 <= ram_wdata;
		if (acc_begin) begin
			sum_q <= xkwd_pkg::MIX_DELTA;
			z_q <= '0;
			cur_q <= '0;
			first_q <= '0;
		end else if (state_q == xkwd_pkg::ST_MIX) begin
			z_q <= ram_wdata;
			cur_q <= y_sel;
			if (p_q == '0) begin
				first_q <= ram_wdata;
			end
			if (p_last) begin
				sum_q <= sum_q + xkwd_pkg::MIX_DELTA;
			end
		end

		if (acc_data) begin
			status_s1 <= ready_q ? xkwd_pkg::STAT_DATA : xkwd_pkg::STAT_EARLY;
			xor_s1 <= ready_q && do_xor;
			word_s1 <= req.data_word;
			last_s1 <= req.last_word;
		end else if (build_done) begin
			status_s1 <= xkwd_pkg::STAT_BEGIN;
			xor_s1 <= 1'b0;
			word_s1 <= '0;
			last_s1 <= 1'b0;
		end

		if (mv) begin
			out_status_q <= status_s1;
			out_word_q <= plain_s1;
			out_xor_q <= (status_s1 == xkwd_pkg::STAT_BEGIN) ? '0 : acc_next;
			out_last_q <= (status_s1 == xkwd_pkg::STAT_BEGIN) ? 1'b0 : last_s1;
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.status = out_status_q;
	assign rsp.plain_word = out_word_q;
	assign rsp.running_xor = out_xor_q;
	assign rsp.last_out = out_last_q;

	// no data item sits in the pipe while the keystream is built
	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != xkwd_pkg::ST_RUN) |-> !v_s1)
		else $error("data stage busy during keystream build");

	// the last mix step hands a begin result to the data stage
	a_begin_result: assert property (@(posedge clk) disable iff (!arst_n)
		build_done |=> (v_s1 && status_s1 == xkwd_pkg::STAT_BEGIN && ready_q))
		else $error("begin result missing after keystream build");

	// keystream reads only come from the begin pass or a taken xor word
	a_read_src: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && state_q == xkwd_pkg::ST_RUN) |-> (acc_data && ready_q && do_xor))
		else $error("stray keystream read");

	a_counter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(words_seen_q <= WSW'(FULL_WORDS)) && (check_cnt_q <= CW'(CHECK_WORDS)))
		else $error("saturating counter out of range");

endmodule

FILE: hdl/xkwd_ram.sv
`timescale 1ns / 1ps

module xkwd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: verif/tb_xxtea_keystream_word_decrypt.sv
`timescale 1ns / 1ps

module tb_xxtea_keystream_word_decrypt;

	localparam int STREAM_WORDS = 1024;
	localparam int ROUND_COUNT = 6;
	localparam int FULL_WORDS = 512;
	localparam int SKIP_STRIDE = 64;
	localparam int CHECK_WORDS = 128;
	localparam int QUIET_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 10;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		xkwd_pkg::status_t status;
		logic [xkwd_pkg::WORD_W-1:0] plain_word;
		logic [xkwd_pkg::WORD_W-1:0] running_xor;
		logic last_out;
	} word_result_t;

	class decrypt_scoreboard;
		word_result_t expected_q[$];
		int unsigned err_count;
		logic [xkwd_pkg::WORD_W-1:0] key_q [xkwd_pkg::KEY_WORDS];
		logic [xkwd_pkg::WORD_W-1:0] stream_mem [STREAM_WORDS];
		bit stream_ready;
		int unsigned words_seen;
		int unsigned stride_phase;
		int unsigned key_index;
		int unsigned check_count;
		logic [xkwd_pkg::WORD_W-1:0] check_acc;

		function new();
			err_count = 0;
			stream_ready = 0;
			for (int i = 0; i < xkwd_pkg::KEY_WORDS; i++) key_q[i] = '0;
			for (int i = 0; i < STREAM_WORDS; i++) stream_mem[i] = '0;
			clear_counters();
		endfunction

		function void clear_counters();
			words_seen = 0;
			stride_phase = 0;
			key_index = 0;
			check_count = 0;
			check_acc = '0;
		endfunction

		function void set_key(int unsigned idx, logic [xkwd_pkg::WORD_W-1:0] val);
			key_q[idx] = val;
		endfunction

		function logic [xkwd_pkg::WORD_W-1:0] round_mix(logic [xkwd_pkg::WORD_W-1:0] y,
			logic [xkwd_pkg::WORD_W-1:0] z, logic [xkwd_pkg::WORD_W-1:0] sum,
			int unsigned p, logic [1:0] e);
			logic [xkwd_pkg::WORD_W-1:0] a;
			logic [xkwd_pkg::WORD_W-1:0] b;
			logic [1:0] sel;
			sel = p[1:0] ^ e;
			a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
			b = (sum ^ y) + (key_q[sel] ^ z);
			return a ^ b;
		endfunction

		function void build_keystream();
			logic [xkwd_pkg::WORD_W-1:0] sum;
			logic [xkwd_pkg::WORD_W-1:0] y;
			logic [xkwd_pkg::WORD_W-1:0] z;
			logic [1:0] e;
			sum = '0;
			for (int i = 0; i < STREAM_WORDS; i++) stream_mem[i] = '0;
			z = stream_mem[STREAM_WORDS-1];
			for (int r = 0; r < ROUND_COUNT; r++) begin
				sum = sum + xkwd_pkg::MIX_DELTA;
				e = sum[3:2];
				for (int p = 0; p < STREAM_WORDS - 1; p++) begin
					y = stream_mem[p+1];
					stream_mem[p] = stream_mem[p] + round_mix(y, z, sum, p, e);
					z = stream_mem[p];
				end
				y = stream_mem[0];
				stream_mem[STREAM_WORDS-1] = stream_mem[STREAM_WORDS-1]
					+ round_mix(y, z, sum, STREAM_WORDS - 1, e);
				z = stream_mem[STREAM_WORDS-1];
			end
		endfunction

		function void note_input(logic cmd, logic [xkwd_pkg::WORD_W-1:0] word, logic last);
			word_result_t r;
			logic hit;
			logic [xkwd_pkg::WORD_W-1:0] w;
			w = word;
			hit = 1'b0;
			r.last_out = last;
			if (cmd == xkwd_pkg::CMD_BEGIN) begin
				build_keystream();
				stream_ready = 1;
				clear_counters();
				r.status = xkwd_pkg::STAT_BEGIN;
				r.plain_word = '0;
				r.running_xor = check_acc;
				r.last_out = 1'b0;
			end else if (!stream_ready) begin
				r.status = xkwd_pkg::STAT_EARLY;
				r.plain_word = word;
				r.running_xor = check_acc;
			end else begin
				if (words_seen < FULL_WORDS) begin
					hit = 1'b1;
					words_seen++;
				end else begin
					hit = (stride_phase == 0);
					stride_phase++;
					if (stride_phase >= SKIP_STRIDE) stride_phase = 0;
				end
				if (hit) begin
					w = w ^ stream_mem[key_index];
					key_index++;
					if (key_index >= STREAM_WORDS) key_index = 0;
				end
				if (check_count < CHECK_WORDS) begin
					check_acc = check_acc ^ w;
					check_count++;
				end
				r.status = xkwd_pkg::STAT_DATA;
				r.plain_word = w;
				r.running_xor = check_acc;
			end
			expected_q.push_back(r);
		endfunction

		function void report_mismatch(string msg);
			err_count++;
			if (err_count <= 200) $display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void check_result(logic [1:0] status, logic [xkwd_pkg::WORD_W-1:0] plain_word,
			logic [xkwd_pkg::WORD_W-1:0] running_xor, logic last_out);
			word_result_t exp;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, status %0d word %08h",
					status, plain_word));
				return;
			end
			exp = expected_q.pop_front();
			if (status !== exp.status)
				report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
			if (plain_word !== exp.plain_word)
				report_mismatch($sformatf("plain_word %08h, expected %08h", plain_word,
					exp.plain_word));
			if (running_xor !== exp.running_xor)
				report_mismatch($sformatf("running_xor %08h, expected %08h", running_xor,
					exp.running_xor));
			if (last_out !== exp.last_out)
				report_mismatch($sformatf("last_out %0b, expected %0b", last_out, exp.last_out));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [xkwd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [xkwd_pkg::WORD_W-1:0] cfg_data;

	xkwd_in_if req_if ();
	xkwd_out_if rsp_if ();

	xxtea_keystream_word_decrypt #(
		.STREAM_WORDS(STREAM_WORDS),
		.ROUND_COUNT(ROUND_COUNT),
		.FULL_WORDS(FULL_WORDS),
		.SKIP_STRIDE(SKIP_STRIDE),
		.CHECK_WORDS(CHECK_WORDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	decrypt_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_rsp = 1'b0;
	int quiet_cycles = 0;

	always #5 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		if (hold_rsp)
			rsp_if.ready <= 1'b0;
		else
			rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && req_if.valid && req_if.ready)
			sb.note_input(req_if.cmd, req_if.data_word, req_if.last_word);
		if (arst_n && rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.status, rsp_if.plain_word, rsp_if.running_xor,
				rsp_if.last_out);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct <= recv_pct;
	endtask

	task automatic send_item(logic cmd, logic [xkwd_pkg::WORD_W-1:0] word, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= cmd;
		req_if.data_word <= word;
		req_if.last_word <= last;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
	endtask

	task automatic send_words(int count);
		for (int i = 0; i < count; i++)
			send_item(xkwd_pkg::CMD_DATA, $urandom, ($urandom_range(31) == 0));
	endtask

	task automatic wait_all_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_keys(logic [xkwd_pkg::WORD_W-1:0] k0, logic [xkwd_pkg::WORD_W-1:0] k1,
		logic [xkwd_pkg::WORD_W-1:0] k2, logic [xkwd_pkg::WORD_W-1:0] k3);
		logic [xkwd_pkg::WORD_W-1:0] vals [xkwd_pkg::KEY_WORDS];
		vals[0] = k0;
		vals[1] = k1;
		vals[2] = k2;
		vals[3] = k3;
		for (int i = 0; i < xkwd_pkg::KEY_WORDS; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[xkwd_pkg::CFG_IDX_W-1:0];
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_key(i, vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic random_keys();
		write_keys($urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.cmd = xkwd_pkg::CMD_DATA;
		req_if.data_word = '0;
		req_if.last_word = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// data before any begin passes through
		set_idling(0, 0);
		send_item(xkwd_pkg::CMD_DATA, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'hffff_ffff, 1'b1);
		send_item(xkwd_pkg::CMD_DATA, 32'h1234_5678, 1'b0);
		// keystream under the reset key
		send_item(xkwd_pkg::CMD_BEGIN, 32'hffff_ffff, 1'b1);
		send_item(xkwd_pkg::CMD_DATA, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'hffff_ffff, 1'b1);
		send_item(xkwd_pkg::CMD_DATA, 32'h8000_0001, 1'b0);
		wait_all_results();
		// new key has no effect until the next begin
		write_keys(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_item(xkwd_pkg::CMD_DATA, 32'h5a5a_5a5a, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'ha5a5_a5a5, 1'b1);
		send_item(xkwd_pkg::CMD_BEGIN, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'hffff_ffff, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'h7fff_fffe, 1'b1);
		// back-to-back begins
		send_item(xkwd_pkg::CMD_BEGIN, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_BEGIN, 32'hffff_ffff, 1'b1);
		send_item(xkwd_pkg::CMD_DATA, 32'hdead_beef, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'h0000_0001, 1'b1);
		wait_all_results();
		write_keys(32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
		send_item(xkwd_pkg::CMD_BEGIN, 32'h0000_0000, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'hcafe_f00d, 1'b0);
		send_item(xkwd_pkg::CMD_DATA, 32'h0f0f_0f0f, 1'b1);
		wait_all_results();

		// past the full-xor region into the stride region, no idling
		random_keys();
		send_item(xkwd_pkg::CMD_BEGIN, $urandom, 1'b0);
		send_words(600);
		wait_all_results();

		set_idling(50, 0);
		random_keys();
		send_item(xkwd_pkg::CMD_BEGIN, $urandom, 1'b0);
		send_words(150);
		send_item(xkwd_pkg::CMD_BEGIN, $urandom, 1'b1);
		send_words(50);
		wait_all_results();

		set_idling(0, 50);
		random_keys();
		send_item(xkwd_pkg::CMD_BEGIN, $urandom, 1'b0);
		send_words(150);
		wait_all_results();

		set_idling(33, 33);
		write_keys(32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000);
		send_item(xkwd_pkg::CMD_BEGIN, $urandom, 1'b0);
		send_words(100);

		// long receiver hold-off while the sender keeps offering
		set_idling(0, 0);
		fork
			begin
				hold_rsp <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp <= 1'b0;
			end
			send_words(150);
		join
		// sender pauses until everything has drained
		wait_all_results();
		set_idling(33, 33);
		send_words(50);

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.expected_q.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
		if (sb.err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/xkwd_pkg.sv
hdl/xkwd_if.sv
hdl/xkwd_ram.sv
hdl/xxtea_keystream_word_decrypt.sv
verif/tb_xxtea_keystream_word_decrypt.sv
